>>> rtl/lcd4_pkg.sv
// Shared types and constants for the 4-bit character LCD command sequencer.
`timescale 1ns / 1ps

package lcd4_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 4;
	localparam int unsigned INIT_LEN        = 14;

	localparam logic [7:0]  FUNC_SET_CMD  = 8'h28;
	localparam logic [7:0]  CURSOR_BASE   = 8'h80;
	localparam logic [3:0]  RESET_NIBBLE  = 4'h3;
	localparam logic [3:0]  FOURBIT_NIBBLE = 4'h2;
	localparam logic [12:0] WAIT_POWERUP  = 13'd4100;
	localparam logic [12:0] WAIT_RESET    = 13'd100;
	localparam logic [12:0] WAIT_CLEAR    = 13'd1520;
	localparam logic [12:0] WAIT_CMD      = 13'd37;
	localparam logic [12:0] WAIT_NONE     = 13'd0;

	typedef enum logic [1:0] {
		KIND_DATA   = 2'd0,
		KIND_INSTR  = 2'd1,
		KIND_CURSOR = 2'd2,
		KIND_INIT   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REG_DISPLAY_OFF = 2'd0,
		REG_CLEAR       = 2'd1,
		REG_ENTRY_MODE  = 2'd2,
		REG_DISPLAY_ON  = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		OP_BYTE = 1'b0,
		OP_INIT = 1'b1
	} op_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
		logic       row;
		logic [5:0] column;
	} request_t;

	typedef struct packed {
		logic        reg_select;
		logic [3:0]  nibble;
		logic [12:0] settle_us;
		logic        last;
	} result_t;

	typedef struct packed {
		op_t        op;
		logic       rs;
		logic [7:0] data;
	} desc_t;

endpackage

>>> rtl/lcd4_front.sv
// Front end: classifies an accepted request into a byte or an initialize job.
`timescale 1ns / 1ps

module lcd4_front (
	input  lcd4_pkg::request_t request,
	output lcd4_pkg::desc_t    desc
);
	import lcd4_pkg::*;

	always_comb begin
		desc.op   = OP_BYTE;
		desc.rs   = 1'b0;
		desc.data = request.value;
		case (kind_t'(request.kind))
			KIND_DATA: begin
				desc.rs = 1'b1;
			end
			KIND_INSTR: begin
				desc.rs = 1'b0;
			end
			KIND_CURSOR: begin
				// The column stays below 64, so it fills only bits 5:0; the row sits in bit 6 and the base in bit 7.
				desc.data = CURSOR_BASE | {1'b0, request.row, request.column};
			end
			KIND_INIT: begin
				desc.op = OP_INIT;
			end
			default: begin
				desc.op = OP_BYTE;
			end
		endcase
	end

endmodule

>>> rtl/lcd4_queue.sv
// Small job queue between the front end and the nibble sequencer.
`timescale 1ns / 1ps

module lcd4_queue #(
	parameter int unsigned DEPTH = lcd4_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  lcd4_pkg::desc_t wr_data,
	output logic            full,
	input  logic            rd_en,
	output logic            rd_valid,
	output lcd4_pkg::desc_t rd_data
);
	import lcd4_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	desc_t         mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign full     = (count_q == FULL_CNT);
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_en & ~full;
	assign do_rd    = rd_en & rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/lcd4_back.sv
// Back end: command registers, sequencer: one nibble beat per cycle unless stalled.
`timescale 1ns / 1ps

module lcd4_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_addr,
	input  logic [7:0]        cfg_wdata,
	input  logic              job_valid,
	input  lcd4_pkg::desc_t   job,
	output logic              job_take,
	output logic              empty,
	input  logic              pop,
	output lcd4_pkg::result_t result
);
	import lcd4_pkg::*;

	localparam logic [3:0] LAST_INIT_STEP = 4'(INIT_LEN - 1);

	logic [7:0] display_off_q;
	logic [7:0] clear_q;
	logic [7:0] entry_mode_q;
	logic [7:0] display_on_q;

	desc_t      cur_q;
	logic       cur_valid_q;
	logic [3:0] step_q;
	result_t    out_q;
	logic       out_valid_q;

	logic       advance;
	logic       emit;
	logic       last_step;
	logic [2:0] byte_sel;
	logic [7:0] init_byte;
	result_t    beat;

	assign advance   = ~out_valid_q | pop;
	assign emit      = cur_valid_q & advance;
	assign last_step = (cur_q.op == OP_INIT) ? (step_q == LAST_INIT_STEP) : step_q[0];
	assign job_take  = job_valid & (~cur_valid_q | (emit & last_step));
	assign byte_sel  = step_q[3:1];
	assign empty     = ~out_valid_q;
	assign result    = out_q;

	always_comb begin
		case (byte_sel)
			3'd2:    init_byte = FUNC_SET_CMD;
			3'd3:    init_byte = display_off_q;
			3'd4:    init_byte = clear_q;
			3'd5:    init_byte = entry_mode_q;
			default: init_byte = display_on_q;
		endcase
	end

	always_comb begin
		beat.reg_select = cur_q.rs;
		beat.nibble     = step_q[0] ? cur_q.data[3:0] : cur_q.data[7:4];
		beat.settle_us  = WAIT_NONE;
		beat.last       = last_step;
		if (cur_q.op == OP_INIT) begin
			beat.reg_select = 1'b0;
			case (step_q)
				4'd0: begin
					beat.nibble    = RESET_NIBBLE;
					beat.settle_us = WAIT_POWERUP;
				end
				4'd1, 4'd2: begin
					beat.nibble    = RESET_NIBBLE;
					beat.settle_us = WAIT_RESET;
				end
				4'd3: begin
					beat.nibble    = FOURBIT_NIBBLE;
					beat.settle_us = WAIT_RESET;
				end
				default: begin
					beat.nibble = step_q[0] ? init_byte[3:0] : init_byte[7:4];
					if (step_q[0]) begin
						beat.settle_us = (byte_sel == 3'd4) ? WAIT_CLEAR : WAIT_CMD;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			display_off_q <= 8'h08;
			clear_q       <= 8'h01;
			entry_mode_q  <= 8'h06;
			display_on_q  <= 8'h0c;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_DISPLAY_OFF: display_off_q <= cfg_wdata;
				REG_CLEAR:       clear_q       <= cfg_wdata;
				REG_ENTRY_MODE:  entry_mode_q  <= cfg_wdata;
				REG_DISPLAY_ON:  display_on_q  <= cfg_wdata;
				default:         display_on_q  <= display_on_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (job_take) begin
			cur_q <= job;
		end
		if (emit) begin
			out_q <= beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (job_take) begin
				cur_valid_q <= 1'b1;
				step_q      <= '0;
			end else if (emit && last_step) begin
				cur_valid_q <= 1'b0;
			end else if (emit) begin
				step_q <= step_q + 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/lcd_4bit_command_sequencer.sv
// Top level of the 4-bit character LCD command sequencer.
//
//   Channel   Handshake           Payload
//   request   push / full         request (kind, value, row, column)
//   result    empty / pop         result (reg_select, nibble, settle_us, last)
//   config    cfg_we              cfg_addr, cfg_wdata
//
// The sequencer emits one beat per cycle unless a held result is not popped: two beats for
// a byte request and fourteen for an initialize, set by its single step counter.
// A request can be taken every cycle until the job queue of QUEUE_DEPTH entries fills.
// A held result only stops the sequencer; the queue keeps taking requests.
// Reset clears the queue, the sequencer and the output register, and loads
// the default command bytes.
`timescale 1ns / 1ps

module lcd_4bit_command_sequencer #(
	parameter int unsigned QUEUE_DEPTH = lcd4_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  lcd4_pkg::request_t request,
	output logic               empty,
	input  logic               pop,
	output lcd4_pkg::result_t  result,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_addr,
	input  logic [7:0]         cfg_wdata
);
	import lcd4_pkg::*;

	desc_t front_desc;
	desc_t queue_desc;
	logic  queue_valid;
	logic  queue_take;

	lcd4_front u_front (
		.request (request),
		.desc    (front_desc)
	);

	lcd4_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (push),
		.wr_data  (front_desc),
		.full     (full),
		.rd_en    (queue_take),
		.rd_valid (queue_valid),
		.rd_data  (queue_desc)
	);

	lcd4_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.job_valid (queue_valid),
		.job       (queue_desc),
		.job_take  (queue_take),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

>>> rtl/lcd4_checker.sv
// Port-level checker for the LCD command sequencer, bound to the top level.
`timescale 1ns / 1ps

module lcd4_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input lcd4_pkg::result_t  result
);
	import lcd4_pkg::*;

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("stalled result beat changed");

	a_data_pair: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && result.reg_select && !result.last
		|=> !empty && result.reg_select && result.last)
		else $error("data high nibble not followed by its low nibble");

	a_powerup_next: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && result.settle_us == WAIT_POWERUP
		|=> !empty && result.nibble == RESET_NIBBLE && result.settle_us == WAIT_RESET)
		else $error("power-up reset beat not followed by second reset beat");

	a_empty_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> empty)
		else $error("result shown right after reset");

endmodule

bind lcd_4bit_command_sequencer lcd4_checker u_lcd4_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

>>> test/lcd4_beat_checker.sv
// Checker that predicts the nibble beats of the LCD command sequencer and compares them.
`timescale 1ns / 1ps

module lcd4_beat_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  lcd4_pkg::request_t request,
	input  logic               empty,
	input  logic               pop,
	input  lcd4_pkg::result_t  result,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_addr,
	input  logic [7:0]         cfg_wdata,
	output int                 failures,
	output int                 outstanding
);
	import lcd4_pkg::*;

	logic [7:0] off_byte;
	logic [7:0] clear_byte;
	logic [7:0] entry_byte;
	logic [7:0] on_byte;
	result_t    expected_beats[$];
	int         fail_total;

	function automatic void add_nibble(input logic rs, input logic [3:0] nib,
			input logic [12:0] settle, input logic lst);
		result_t beat;
		beat.reg_select = rs;
		beat.nibble     = nib;
		beat.settle_us  = settle;
		beat.last       = lst;
		expected_beats.push_back(beat);
	endfunction

	function automatic void add_byte(input logic rs, input logic [7:0] data,
			input logic [12:0] settle, input logic lst);
		add_nibble(rs, data[7:4], WAIT_NONE, 1'b0);
		add_nibble(rs, data[3:0], settle, lst);
	endfunction

	function automatic void expand_request(input request_t rq);
		case (kind_t'(rq.kind))
			KIND_DATA: begin
				add_byte(1'b1, rq.value, WAIT_NONE, 1'b1);
			end
			KIND_INSTR: begin
				add_byte(1'b0, rq.value, WAIT_NONE, 1'b1);
			end
			KIND_CURSOR: begin
				add_byte(1'b0, CURSOR_BASE + {1'b0, rq.row, rq.column}, WAIT_NONE, 1'b1);
			end
			default: begin
				add_nibble(1'b0, RESET_NIBBLE, WAIT_POWERUP, 1'b0);
				add_nibble(1'b0, RESET_NIBBLE, WAIT_RESET, 1'b0);
				add_nibble(1'b0, RESET_NIBBLE, WAIT_RESET, 1'b0);
				add_nibble(1'b0, FOURBIT_NIBBLE, WAIT_RESET, 1'b0);
				add_byte(1'b0, FUNC_SET_CMD, WAIT_CMD, 1'b0);
				add_byte(1'b0, off_byte, WAIT_CMD, 1'b0);
				add_byte(1'b0, clear_byte, WAIT_CLEAR, 1'b0);
				add_byte(1'b0, entry_byte, WAIT_CMD, 1'b0);
				add_byte(1'b0, on_byte, WAIT_CMD, 1'b1);
			end
		endcase
	endfunction

	function automatic void check_beat(input result_t got);
		result_t want;
		want = expected_beats.pop_front();
		if (got.reg_select !== want.reg_select) begin
			$error("reg_select: expected %0d, actual %0d", want.reg_select, got.reg_select);
			fail_total++;
		end
		if (got.nibble !== want.nibble) begin
			$error("nibble: expected %0h, actual %0h", want.nibble, got.nibble);
			fail_total++;
		end
		if (got.settle_us !== want.settle_us) begin
			$error("settle_us: expected %0d, actual %0d", want.settle_us, got.settle_us);
			fail_total++;
		end
		if (got.last !== want.last) begin
			$error("last: expected %0d, actual %0d", want.last, got.last);
			fail_total++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_byte   = 8'h08;
			clear_byte = 8'h01;
			entry_byte = 8'h06;
			on_byte    = 8'h0C;
			expected_beats.delete();
			fail_total = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_addr))
					REG_DISPLAY_OFF: off_byte   = cfg_wdata;
					REG_CLEAR:       clear_byte = cfg_wdata;
					REG_ENTRY_MODE:  entry_byte = cfg_wdata;
					REG_DISPLAY_ON:  on_byte    = cfg_wdata;
					default:         on_byte    = on_byte;
				endcase
			end
			if (pop && !empty) begin
				if (expected_beats.size() == 0) begin
					$error("result beat with no expected beat waiting: %p", result);
					fail_total++;
				end else begin
					check_beat(result);
				end
			end
			if (push && !full)
				expand_request(request);
		end
		failures    <= fail_total;
		outstanding <= expected_beats.size();
	end

endmodule

>>> test/tb_top.sv
// Testbench top for the LCD command sequencer: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_top;
	import lcd4_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 4000;
	localparam int PHASE_ITEMS = 137;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	request_t   request = '0;
	logic       empty;
	logic       pop = 1'b0;
	result_t    result;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_addr = '0;
	logic [7:0] cfg_wdata = '0;
	int         failures;
	int         outstanding;
	int         send_idle = 0;
	int         recv_idle = 0;
	bit         hold_off_req = 1'b0;
	int         stall_cycles = 0;

	lcd_4bit_command_sequencer uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.request(request),
		.empty(empty),
		.pop(pop),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	lcd4_beat_checker beat_checker (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.request(request),
		.empty(empty),
		.pop(pop),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.failures(failures),
		.outstanding(outstanding)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic send_request(input kind_t kind, input logic [7:0] value,
			input logic row, input logic [5:0] column);
		request_t rq;
		rq.kind   = kind;
		rq.value  = value;
		rq.row    = row;
		rq.column = column;
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push    <= 1'b1;
		request <= rq;
		do
			@(posedge clk);
		while (full);
	endtask

	task automatic send_random();
		send_request(kind_t'($urandom_range(3)), 8'($urandom_range(255)),
			1'($urandom_range(1)), 6'($urandom_range(63)));
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [7:0] data);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	task automatic write_commands(input logic [7:0] off_cmd, input logic [7:0] clr_cmd,
			input logic [7:0] entry_cmd, input logic [7:0] on_cmd);
		write_reg(REG_DISPLAY_OFF, off_cmd);
		write_reg(REG_CLEAR, clr_cmd);
		write_reg(REG_ENTRY_MODE, entry_cmd);
		write_reg(REG_DISPLAY_ON, on_cmd);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(input int s_idle, input int r_idle, input bit hold);
		write_commands(8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)));
		send_idle = s_idle;
		recv_idle = r_idle;
		if (hold)
			hold_off_req = 1'b1;
		repeat (PHASE_ITEMS) send_random();
		drain();
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				pop <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(KIND_DATA, 8'h00, 1'b0, 6'd0);
		send_request(KIND_DATA, 8'hFF, 1'b1, 6'd63);
		send_request(KIND_DATA, 8'hA5, 1'b0, 6'd0);
		send_request(KIND_INSTR, 8'h00, 1'b0, 6'd0);
		send_request(KIND_INSTR, 8'hFF, 1'b1, 6'd63);
		send_request(KIND_INSTR, 8'h5A, 1'b0, 6'd0);
		send_request(KIND_CURSOR, 8'h00, 1'b0, 6'd0);
		send_request(KIND_CURSOR, 8'hFF, 1'b1, 6'd63);
		send_request(KIND_CURSOR, 8'h00, 1'b0, 6'd63);
		send_request(KIND_CURSOR, 8'h00, 1'b1, 6'd0);
		send_request(KIND_INIT, 8'h00, 1'b0, 6'd0);
		send_request(KIND_INIT, 8'hFF, 1'b1, 6'd63);
		drain();

		write_commands(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_request(KIND_INIT, 8'h3C, 1'b0, 6'd21);
		send_request(KIND_DATA, 8'h3C, 1'b1, 6'd42);
		drain();

		write_commands(8'h00, 8'h00, 8'h00, 8'h00);
		send_request(KIND_INIT, 8'hC3, 1'b1, 6'd42);
		send_request(KIND_CURSOR, 8'hC3, 1'b1, 6'd21);
		drain();

		run_phase(29, 48, 1'b0);
		run_phase(48, 29, 1'b0);
		run_phase(0, 0, 1'b1);

		if (failures == 0 && outstanding == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
